@@ hw/rtl/tfpu_pkg.sv @@
// Shared constants and types of the three-frequency phase unwrap block.
package tfpu_pkg;

    localparam int PHASE_BITS = 16;
    localparam int IN_W       = 16;
    localparam int RATIO_W    = 24;
    localparam int BIAS_W     = 16;
    localparam int CFG_W      = 24;
    localparam int REG_IDX_W  = 2;
    localparam int OUT_W      = 32;
    localparam int ORDER_W    = 16;
    localparam int FRAC_SHIFT = PHASE_BITS + 16;
    localparam int LATENCY    = 8;

    typedef logic [PHASE_BITS-1:0] phase_t;

    typedef struct packed {
        phase_t p1;
        phase_t p23;
        phase_t p123;
    } het_t;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_RATIO_COARSE = 2'd0,
        REG_RATIO_FINE   = 2'd1,
        REG_ROUND_BIAS   = 2'd2
    } reg_index_t;

    localparam logic [RATIO_W-1:0] RATIO_COARSE_RST = 24'd65536;
    localparam logic [RATIO_W-1:0] RATIO_FINE_RST   = 24'd65536;
    localparam logic [BIAS_W-1:0]  ROUND_BIAS_RST   = 16'd2086;

endpackage

@@ hw/rtl/tfpu_heterodyne.sv @@
// Input stage: take the low phase bits and form the wrapped heterodyne differences.
module tfpu_heterodyne
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [tfpu_pkg::IN_W-1:0] phase_high,
    input  logic [tfpu_pkg::IN_W-1:0] phase_mid,
    input  logic [tfpu_pkg::IN_W-1:0] phase_low,
    output logic                      out_valid,
    output tfpu_pkg::het_t            het
);
    import tfpu_pkg::*;

    phase_t p1;
    phase_t p2;
    phase_t p3;
    phase_t p12;
    phase_t p23;
    logic   valid_reg;
    het_t   het_reg;
    het_t   het_next;

    always_comb
    begin
        p1  = PHASE_BITS'(phase_high);
        p2  = PHASE_BITS'(phase_mid);
        p3  = PHASE_BITS'(phase_low);
        p12 = p1 - p2;
        p23 = p2 - p3;
        het_next.p1   = p1;
        het_next.p23  = p23;
        het_next.p123 = p12 - p23;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            het_reg <= het_next;
        end
    end

    assign out_valid = valid_reg;
    assign het       = het_reg;

endmodule

@@ hw/rtl/three_frequency_phase_unwrap.sv @@
// Top level: three-frequency heterodyne phase unwrap pipeline.
//
//  channel | ports                                         | handshake
//  --------+-----------------------------------------------+-------------------------
//  item in | phase_high, phase_mid, phase_low              | start high, busy low
//  result  | unwrapped_phase, fringe_order                 | done high for one cycle
//  config  | wr_index, wr_data                             | wr_en high
//
// One item per clock; busy never rises. Each item passes through eight register
// stages: differences, two multiply stages, two rounding stages, two bias sums and
// the saturating output register.
// Reset clears the stage valid bits and loads the register defaults.
// The receiver takes every result as it appears, so nothing in the pipeline stalls.
module three_frequency_phase_unwrap
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [tfpu_pkg::IN_W-1:0]         phase_high,
    input  logic [tfpu_pkg::IN_W-1:0]         phase_mid,
    input  logic [tfpu_pkg::IN_W-1:0]         phase_low,
    output logic                              done,
    output logic signed [tfpu_pkg::OUT_W-1:0] unwrapped_phase,
    output logic signed [tfpu_pkg::ORDER_W-1:0] fringe_order,
    input  logic                              wr_en,
    input  logic [tfpu_pkg::REG_IDX_W-1:0]    wr_index,
    input  logic [tfpu_pkg::CFG_W-1:0]        wr_data
);
    import tfpu_pkg::*;

    localparam int PB       = PHASE_BITS;
    localparam int PROD1_W  = RATIO_W + PB;
    localparam int X23_W    = PROD1_W + 2;
    localparam int K23_W    = X23_W + 1 - FRAC_SHIFT;
    localparam int U23_W    = K23_W + PB + 1;
    localparam int PROD2_W  = RATIO_W + 1 + U23_W;
    localparam int X1_W     = PROD2_W + 1;
    localparam int K1_W     = X1_W + 1 - FRAC_SHIFT;
    localparam int SCALE_W  = (PB > 16) ? PB : 16;
    localparam int BIAS_UP  = (PB > 16) ? PB - 16 : 0;
    localparam int BIAS_DN  = (PB < 16) ? 16 - PB : 0;

    localparam logic [X23_W:0] HALF23 = (X23_W + 1)'(1) << (FRAC_SHIFT - 1);
    localparam logic [X1_W:0]  HALF1  = (X1_W + 1)'(1) << (FRAC_SHIFT - 1);

    logic [RATIO_W-1:0] ratio_coarse_reg;
    logic [RATIO_W-1:0] ratio_fine_reg;
    logic [BIAS_W-1:0]  round_bias_reg;
    phase_t             bias_ph;
    logic [15:0]        frac16;

    logic               accept;
    logic               v1;
    het_t               het;
    logic [LATENCY:2]   valid_reg;

    logic [PROD1_W-1:0]       prod1_reg;
    phase_t                   p1_s2_reg, p23_s2_reg;
    logic [X23_W-1:0]         x23_reg;
    logic [X23_W-1:0]         x23_next;
    phase_t                   p1_s3_reg, p23_s3_reg;
    logic [X23_W:0]           rnd23;
    logic [K23_W-1:0]         k23;
    logic [U23_W-1:0]         u23_reg;
    logic [U23_W-1:0]         u23_next;
    phase_t                   p1_s4_reg;
    logic signed [PROD2_W-1:0] prod2_reg;
    phase_t                   p1_s5_reg;
    logic [X1_W-1:0]          x1_reg;
    logic [X1_W-1:0]          x1_next;
    logic [15:0]              frac_s6_reg;
    logic [X1_W:0]            rnd1;
    logic [K1_W-1:0]          k1_reg;
    logic [15:0]              frac_s7_reg;
    logic                     sat_hi;
    logic                     sat_lo;
    logic [OUT_W-1:0]         unwrapped_reg;
    logic [OUT_W-1:0]         unwrapped_next;
    logic [ORDER_W-1:0]       order_reg;
    logic [ORDER_W-1:0]       order_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_coarse_reg <= RATIO_COARSE_RST;
            ratio_fine_reg   <= RATIO_FINE_RST;
            round_bias_reg   <= ROUND_BIAS_RST;
        end
        else if (wr_en)
        begin
            case (reg_index_t'(wr_index))
                REG_RATIO_COARSE: ratio_coarse_reg <= wr_data[RATIO_W-1:0];
                REG_RATIO_FINE:   ratio_fine_reg   <= wr_data[RATIO_W-1:0];
                REG_ROUND_BIAS:   round_bias_reg   <= wr_data[BIAS_W-1:0];
                default:          ;
            endcase
        end
    end

    assign bias_ph = PB'((SCALE_W'(round_bias_reg) << BIAS_UP) >> BIAS_DN);

    tfpu_heterodyne u_het
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (accept),
        .phase_high (phase_high),
        .phase_mid  (phase_mid),
        .phase_low  (phase_low),
        .out_valid  (v1),
        .het        (het)
    );

    always_comb
    begin
        x23_next = X23_W'(prod1_reg) - X23_W'({p23_s2_reg, 16'd0})
                 + X23_W'({bias_ph, 16'd0});
        rnd23    = {x23_reg[X23_W-1], x23_reg} + HALF23
                 - (X23_W + 1)'(x23_reg[X23_W-1]);
        k23      = rnd23[X23_W:FRAC_SHIFT];
        u23_next = {k23[K23_W-1], k23, {PB{1'b0}}} + U23_W'(p23_s3_reg);
        x1_next  = {prod2_reg[PROD2_W-1], prod2_reg} - X1_W'({p1_s5_reg, 16'd0})
                 + X1_W'({bias_ph, 16'd0});
        frac16   = 16'((SCALE_W'(p1_s5_reg) << BIAS_DN) >> BIAS_UP);
        rnd1     = {x1_reg[X1_W-1], x1_reg} + HALF1 - (X1_W + 1)'(x1_reg[X1_W-1]);
    end

    always_comb
    begin
        sat_hi = !k1_reg[K1_W-1] && (|k1_reg[K1_W-2:15]);
        sat_lo = k1_reg[K1_W-1] && !(&k1_reg[K1_W-2:15]);
        if (sat_hi)
        begin
            unwrapped_next = {1'b0, {(OUT_W-1){1'b1}}};
            order_next     = {1'b0, {(ORDER_W-1){1'b1}}};
        end
        else if (sat_lo)
        begin
            unwrapped_next = {1'b1, {(OUT_W-1){1'b0}}};
            order_next     = {1'b1, {(ORDER_W-1){1'b0}}};
        end
        else
        begin
            unwrapped_next = {k1_reg[15:0], frac_s7_reg};
            order_next     = k1_reg[ORDER_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[LATENCY-1:2], v1};
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg     <= PROD1_W'(ratio_coarse_reg) * PROD1_W'(het.p123);
        p1_s2_reg     <= het.p1;
        p23_s2_reg    <= het.p23;
        x23_reg       <= x23_next;
        p1_s3_reg     <= p1_s2_reg;
        p23_s3_reg    <= p23_s2_reg;
        u23_reg       <= u23_next;
        p1_s4_reg     <= p1_s3_reg;
        prod2_reg     <= $signed({1'b0, ratio_fine_reg}) * $signed(u23_reg);
        p1_s5_reg     <= p1_s4_reg;
        x1_reg        <= x1_next;
        frac_s6_reg   <= frac16;
        k1_reg        <= rnd1[X1_W:FRAC_SHIFT];
        frac_s7_reg   <= frac_s6_reg;
        unwrapped_reg <= unwrapped_next;
        order_reg     <= order_next;
    end

    assign done            = valid_reg[LATENCY];
    assign unwrapped_phase = unwrapped_reg;
    assign fringe_order    = order_reg;

endmodule

@@ hw/rtl/tfpu_checker.sv @@
// Port-level checker for the phase unwrap block, with its bind.
module tfpu_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              done,
    input logic signed [tfpu_pkg::OUT_W-1:0] unwrapped_phase,
    input logic signed [tfpu_pkg::ORDER_W-1:0] fringe_order
);
    import tfpu_pkg::*;

    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy == 1'b0)
        else $error("busy raised");

    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("item produced no result");

    a_result_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without item");

    a_order_matches_phase: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (unwrapped_phase[OUT_W-1:OUT_W-ORDER_W] == fringe_order))
        else $error("order and integer turns disagree");

endmodule

bind three_frequency_phase_unwrap tfpu_checker u_tfpu_checker
(
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .done            (done),
    .unwrapped_phase (unwrapped_phase),
    .fringe_order    (fringe_order)
);
